// ===== hdl/avc_pkg.sv =====
`default_nettype none

package avc_pkg;

    // field widths
    localparam int ADC_W      = 12;
    localparam int SEL_W      = 2;
    localparam int SMP_W      = 16;
    localparam int DAC_W      = 12;
    localparam int LED_W      = 6;
    localparam int KNOB_N     = 4;
    localparam int KNOB_IDX_W = 2;
    localparam int KNOB_W     = 12;
    localparam int SMOOTH_W   = 16;
    localparam int HOLD_W     = 13;
    localparam int THR_W      = 11;
    localparam int CFG_W      = 13;
    localparam int CFG_IDX_W  = 2;

    // shared multiplier: knob squared, then signed sample times unsigned 12-bit gain
    localparam int MUL_A_W     = SMP_W + 1;
    localparam int MUL_B_W     = KNOB_W + 1;
    localparam int PROD_W      = MUL_A_W + MUL_B_W;
    localparam int GAIN_SHIFT  = 12;
    localparam int SCALE_SHIFT = 14;
    localparam int SCALED_W    = PROD_W - SCALE_SHIFT;

    // output limit
    localparam int OUT_MAX = 2047;

    // knob that sets the volume
    localparam logic [KNOB_IDX_W-1:0] MAIN_KNOB = 2'd0;

    // register reset values
    localparam logic [THR_W-1:0]  VU_LOW_RESET  = 11'd128;
    localparam logic [THR_W-1:0]  VU_HIGH_RESET = 11'd512;
    localparam logic [HOLD_W-1:0] HOLD_RESET    = 13'd4800;

    // adc dnl correction
    localparam int DNL_OFFSET = 512;
    localparam int DNL_PERIOD = 511;
    localparam int DNL_A_W    = ADC_W + 1;
    localparam int DNL_MULTS  = ((1 << ADC_W) - 1 + DNL_OFFSET) / DNL_PERIOD;
    localparam int DNL_BUMP   = 4;

    // iir smoother
    localparam int SMOOTH_ACC_W = SMOOTH_W + 6;
    localparam int SMOOTH_SHIFT = 5;
    localparam int LEVEL_SHIFT  = 4;

    // adc input select codes
    typedef enum logic [SEL_W-1:0] {
        SEL_CV      = 2'd0,
        SEL_AUDIO_R = 2'd1,
        SEL_AUDIO_L = 2'd2,
        SEL_KNOBS   = 2'd3
    } adc_sel_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VU_LOW    = 2'd0,
        CFG_VU_HIGH   = 2'd1,
        CFG_CLIP_HOLD = 2'd2
    } cfg_idx_t;

endpackage

`default_nettype wire

// ===== hdl/audio_volume_clip_vu_knob_smoother.sv =====
`default_nettype none

// channel   direction  handshake              payload
// input     in         in_valid / in_ready    adc_value adc_input audio_present
//                                             left_sample right_sample
// output    out        out_valid / out_ready  dac_left dac_right led_pattern
//                                             knob_updated knob_index knob_value
// config    in         cfg_we                 cfg_index cfg_data
//
// After an input transfer in_ready stays low until the block is idle again, so a
// transfer is finished before the next is taken: one multiplier is used three
// times in turn (knob squared, left scale, right scale), then a final step
// commits the result, the knob smoother and the clip counters, registering the
// outputs; it waits while the output register still holds an untaken result.
// Reset clears all state and loads the register defaults; no clearing pass.

module audio_volume_clip_vu_knob_smoother
    import avc_pkg::*;
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [ADC_W-1:0]             adc_value,
    input  wire logic [SEL_W-1:0]             adc_input,
    input  wire logic                         audio_present,
    input  wire logic signed [SMP_W-1:0]      left_sample,
    input  wire logic signed [SMP_W-1:0]      right_sample,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic signed [DAC_W-1:0]           dac_left,
    output logic signed [DAC_W-1:0]           dac_right,
    output logic [LED_W-1:0]                  led_pattern,
    output logic                              knob_updated,
    output logic [KNOB_IDX_W-1:0]             knob_index,
    output logic [KNOB_W-1:0]                 knob_value,
    input  wire logic                         cfg_we,
    input  wire logic [CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [CFG_W-1:0]             cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_GAIN,
        S_LEFT,
        S_RIGHT,
        S_FIN
    } state_t;

    state_t                       state_reg, state_next;
    logic [ADC_W-1:0]             adc_reg, adc_next;
    adc_sel_t                     sel_reg, sel_next;
    logic signed [SMP_W-1:0]      held_left_reg, held_left_next;
    logic signed [SMP_W-1:0]      held_right_reg, held_right_next;
    logic [KNOB_W-1:0]            gain_reg, gain_next;
    logic signed [PROD_W-1:0]     prod_reg, prod_next;
    logic [KNOB_IDX_W-1:0]        mux_reg, mux_next;
    logic [SMOOTH_W-1:0]          smooth_reg [KNOB_N];
    logic [SMOOTH_W-1:0]          smooth_next [KNOB_N];
    logic [KNOB_W-1:0]            level_reg [KNOB_N];
    logic [KNOB_W-1:0]            level_next [KNOB_N];
    logic [HOLD_W-1:0]            lc_reg, lc_next;
    logic [HOLD_W-1:0]            rc_reg, rc_next;
    logic [THR_W-1:0]             vu_low_reg, vu_low_next;
    logic [THR_W-1:0]             vu_high_reg, vu_high_next;
    logic [HOLD_W-1:0]            hold_reg, hold_next;
    logic signed [DAC_W-1:0]      dl_reg, dl_next;
    logic                         vu_hi_l_reg, vu_hi_l_next;
    logic                         vu_lo_l_reg, vu_lo_l_next;
    logic                         out_valid_reg, out_valid_next;
    logic signed [DAC_W-1:0]      dac_left_reg, dac_left_next;
    logic signed [DAC_W-1:0]      dac_right_reg, dac_right_next;
    logic [LED_W-1:0]             led_reg, led_next;
    logic                         kupd_reg, kupd_next;
    logic [KNOB_IDX_W-1:0]        kidx_reg, kidx_next;
    logic [KNOB_W-1:0]            kval_reg, kval_next;

    // true when a (adc plus 512) lands on a multiple of 511
    function automatic logic dnl_hit(input logic [DNL_A_W-1:0] a);
        logic hit;
        hit = 1'b0;
        for (int k = 1; k <= DNL_MULTS; k++)
        begin
            if (a == DNL_A_W'(k * DNL_PERIOD))
            begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    // shared multiplier operands
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic [KNOB_W-1:0]         main_level;

    assign main_level = level_reg[MAIN_KNOB];

    always_comb
    begin
        unique case (state_reg)
            S_GAIN:
            begin
                mul_a = $signed({{(MUL_A_W-KNOB_W){1'b0}}, main_level});
                mul_b = $signed({1'b0, main_level});
            end
            S_LEFT:
            begin
                mul_a = MUL_A_W'(held_left_reg);
                mul_b = $signed({1'b0, prod_reg[GAIN_SHIFT +: KNOB_W]});
            end
            default:
            begin
                mul_a = MUL_A_W'(held_right_reg);
                mul_b = $signed({1'b0, gain_reg});
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // scale, saturate and level-compare the registered product
    logic signed [SCALED_W-1:0] scaled;
    logic                       clip;
    logic signed [DAC_W-1:0]    sat;
    logic [DAC_W-1:0]           mag_full;
    logic [THR_W-1:0]           mag;
    logic                       vu_hi, vu_lo;

    always_comb
    begin
        scaled = SCALED_W'(prod_reg >>> SCALE_SHIFT);
        clip   = 1'b0;
        if (scaled > OUT_MAX)
        begin
            sat  = DAC_W'(OUT_MAX);
            clip = 1'b1;
        end
        else if (scaled < -OUT_MAX)
        begin
            sat  = DAC_W'(-OUT_MAX);
            clip = 1'b1;
        end
        else
        begin
            sat = scaled[DAC_W-1:0];
        end
        mag_full = sat[DAC_W-1] ? DAC_W'(-sat) : DAC_W'(sat);
        mag      = mag_full[THR_W-1:0];
        vu_hi    = mag > vu_high_reg;
        vu_lo    = mag > vu_low_reg;
    end

    // dnl correction of the latched adc value
    logic [DNL_A_W-1:0] dnl_a;
    logic [DNL_A_W-1:0] dnl_sum;

    always_comb
    begin
        dnl_a   = DNL_A_W'(adc_reg) + DNL_A_W'(DNL_OFFSET);
        dnl_sum = DNL_A_W'(adc_reg)
                + (dnl_hit(dnl_a) ? DNL_A_W'(DNL_BUMP) : DNL_A_W'(0))
                - DNL_A_W'({dnl_a[DNL_A_W-1:10], 3'b000});
    end

    // first-order smoother for the knob behind the mux
    logic [KNOB_IDX_W-1:0]   knob_k;
    logic [SMOOTH_W-1:0]     smooth_old;
    logic [SMOOTH_ACC_W-1:0] smooth_acc;
    logic [SMOOTH_W-1:0]     smooth_new;
    logic [KNOB_W-1:0]       level_new;

    always_comb
    begin
        knob_k     = mux_reg + KNOB_IDX_W'(3);
        smooth_old = smooth_reg[knob_k];
        smooth_acc = SMOOTH_ACC_W'({smooth_old, 5'b00000})
                   - SMOOTH_ACC_W'(smooth_old)
                   + SMOOTH_ACC_W'({adc_reg, 4'b0000});
        smooth_new = smooth_acc[SMOOTH_SHIFT +: SMOOTH_W];
        level_new  = smooth_new[LEVEL_SHIFT +: KNOB_W];
    end

    // right clip count after this tick's load
    logic [HOLD_W-1:0] rc_loaded;
    logic              out_free;

    assign rc_loaded = clip ? hold_reg : rc_reg;
    assign out_free  = !out_valid_reg || out_ready;

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        adc_next        = adc_reg;
        sel_next        = sel_reg;
        held_left_next  = held_left_reg;
        held_right_next = held_right_reg;
        gain_next       = gain_reg;
        prod_next       = prod_reg;
        mux_next        = mux_reg;
        smooth_next     = smooth_reg;
        level_next      = level_reg;
        lc_next         = lc_reg;
        rc_next         = rc_reg;
        vu_low_next     = vu_low_reg;
        vu_high_next    = vu_high_reg;
        hold_next       = hold_reg;
        dl_next         = dl_reg;
        vu_hi_l_next    = vu_hi_l_reg;
        vu_lo_l_next    = vu_lo_l_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        dac_left_next   = dac_left_reg;
        dac_right_next  = dac_right_reg;
        led_next        = led_reg;
        kupd_next       = kupd_reg;
        kidx_next       = kidx_reg;
        kval_next       = kval_reg;

        // configuration writes
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_VU_LOW:    vu_low_next  = cfg_data[THR_W-1:0];
                CFG_VU_HIGH:   vu_high_next = cfg_data[THR_W-1:0];
                CFG_CLIP_HOLD: hold_next    = cfg_data[HOLD_W-1:0];
                default:       ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    adc_next = adc_value;
                    sel_next = adc_sel_t'(adc_input);
                    if (audio_present)
                    begin
                        held_left_next  = left_sample;
                        held_right_next = right_sample;
                    end
                    state_next = S_GAIN;
                end
            end
            S_GAIN:
            begin
                prod_next  = mul_p;
                adc_next   = dnl_sum[ADC_W-1:0];
                state_next = S_LEFT;
            end
            S_LEFT:
            begin
                gain_next  = prod_reg[GAIN_SHIFT +: KNOB_W];
                prod_next  = mul_p;
                state_next = S_RIGHT;
            end
            S_RIGHT:
            begin
                dl_next      = sat;
                vu_hi_l_next = vu_hi;
                vu_lo_l_next = vu_lo;
                if (clip)
                begin
                    lc_next = hold_reg;
                end
                prod_next  = mul_p;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    dac_left_next  = dl_reg;
                    dac_right_next = sat;
                    led_next       = {vu_lo, vu_lo_l_reg, vu_hi, vu_hi_l_reg,
                                      rc_loaded != '0, lc_reg != '0};
                    kupd_next      = 1'b0;
                    kidx_next      = '0;
                    kval_next      = '0;
                    if (sel_reg == SEL_AUDIO_L)
                    begin
                        mux_next = mux_reg + KNOB_IDX_W'(1);
                    end
                    else if (sel_reg == SEL_KNOBS)
                    begin
                        smooth_next[knob_k] = smooth_new;
                        level_next[knob_k]  = level_new;
                        kupd_next           = 1'b1;
                        kidx_next           = knob_k;
                        kval_next           = level_new;
                    end
                    // hold counters count down at the end of the tick
                    lc_next    = lc_reg - HOLD_W'(lc_reg != '0);
                    rc_next    = rc_loaded - HOLD_W'(rc_loaded != '0);
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            adc_reg        <= '0;
            sel_reg        <= SEL_CV;
            held_left_reg  <= '0;
            held_right_reg <= '0;
            gain_reg       <= '0;
            prod_reg       <= '0;
            mux_reg        <= '0;
            for (int i = 0; i < KNOB_N; i++)
            begin
                smooth_reg[i] <= '0;
                level_reg[i]  <= '0;
            end
            lc_reg         <= '0;
            rc_reg         <= '0;
            vu_low_reg     <= VU_LOW_RESET;
            vu_high_reg    <= VU_HIGH_RESET;
            hold_reg       <= HOLD_RESET;
            dl_reg         <= '0;
            vu_hi_l_reg    <= 1'b0;
            vu_lo_l_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            dac_left_reg   <= '0;
            dac_right_reg  <= '0;
            led_reg        <= '0;
            kupd_reg       <= 1'b0;
            kidx_reg       <= '0;
            kval_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            adc_reg        <= adc_next;
            sel_reg        <= sel_next;
            held_left_reg  <= held_left_next;
            held_right_reg <= held_right_next;
            gain_reg       <= gain_next;
            prod_reg       <= prod_next;
            mux_reg        <= mux_next;
            smooth_reg     <= smooth_next;
            level_reg      <= level_next;
            lc_reg         <= lc_next;
            rc_reg         <= rc_next;
            vu_low_reg     <= vu_low_next;
            vu_high_reg    <= vu_high_next;
            hold_reg       <= hold_next;
            dl_reg         <= dl_next;
            vu_hi_l_reg    <= vu_hi_l_next;
            vu_lo_l_reg    <= vu_lo_l_next;
            out_valid_reg  <= out_valid_next;
            dac_left_reg   <= dac_left_next;
            dac_right_reg  <= dac_right_next;
            led_reg        <= led_next;
            kupd_reg       <= kupd_next;
            kidx_reg       <= kidx_next;
            kval_reg       <= kval_next;
        end
    end

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign dac_left     = dac_left_reg;
    assign dac_right    = dac_right_reg;
    assign led_pattern  = led_reg;
    assign knob_updated = kupd_reg;
    assign knob_index   = kidx_reg;
    assign knob_value   = kval_reg;

endmodule

`default_nettype wire

// ===== hdl/avc_checker.sv =====
`default_nettype none

module avc_checker
    import avc_pkg::*;
(
    input wire logic                     clk,
    input wire logic                     rst_n,
    input wire logic                     in_valid,
    input wire logic                     in_ready,
    input wire logic                     out_valid,
    input wire logic                     out_ready,
    input wire logic signed [DAC_W-1:0]  dac_left,
    input wire logic signed [DAC_W-1:0]  dac_right,
    input wire logic [LED_W-1:0]         led_pattern,
    input wire logic                     knob_updated,
    input wire logic [KNOB_IDX_W-1:0]    knob_index,
    input wire logic [KNOB_W-1:0]        knob_value
);

    // one item at a time: no transfer in the cycle after an input transfer
    a_busy_after_transfer: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready
    ) else $error("input taken again right after a transfer");

    // a stalled result holds
    a_out_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(dac_left) && $stable(dac_right)
            && $stable(led_pattern) && $stable(knob_value)
    ) else $error("stalled result changed");

    // dac outputs stay inside the saturation limits
    a_dac_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> dac_left >= -OUT_MAX && dac_left <= OUT_MAX
            && dac_right >= -OUT_MAX && dac_right <= OUT_MAX
    ) else $error("dac output beyond limit");

    // knob fields are zero when no knob was updated
    a_knob_quiet: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid && !knob_updated |-> knob_index == '0 && knob_value == '0
    ) else $error("knob fields set without a knob update");

endmodule

bind audio_volume_clip_vu_knob_smoother avc_checker u_avc_checker (.*);

`default_nettype wire
